@@ src/pidc_pkg.sv @@
// Shared widths, register indexes and a helper function for the clamped positional PID block.
package pidc_pkg;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Sample and state widths.
   localparam int ERROR_WIDTH = 16;
   localparam int INTEG_WIDTH = 24;
   localparam int DIFF_WIDTH  = ERROR_WIDTH + 1;

   // Register widths.
   localparam int GAIN_WIDTH  = 16;
   localparam int ILIM_WIDTH  = 23;
   localparam int SEP_WIDTH   = 15;
   localparam int DLIM_WIDTH  = 16;
   localparam int OLIM_WIDTH  = 15;
   localparam int DRIVE_WIDTH = 16;

   // Register port.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 23;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEG_LIM  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEP_THRESH = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DERIV_LIM  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUT_LIM    = 3'd6;

   // Reset values of the limit registers.
   localparam logic [ILIM_WIDTH-1:0] INTEG_LIM_RESET  = {ILIM_WIDTH{1'b1}};
   localparam logic [SEP_WIDTH-1:0]  SEP_THRESH_RESET = {SEP_WIDTH{1'b1}};
   localparam logic [DLIM_WIDTH-1:0] DERIV_LIM_RESET  = {DLIM_WIDTH{1'b1}};
   localparam logic [OLIM_WIDTH-1:0] OUT_LIM_RESET    = {OLIM_WIDTH{1'b1}};

   // Internal arithmetic widths.
   localparam int ISUM_WIDTH = max_int(INTEG_WIDTH, ERROR_WIDTH) + 1;
   localparam int LIMC_WIDTH = max_int(ILIM_WIDTH, INTEG_WIDTH - 1);
   localparam int SEPC_WIDTH = max_int(ERROR_WIDTH, SEP_WIDTH);
   localparam int DCMP_WIDTH = max_int(DIFF_WIDTH, DLIM_WIDTH + 1);
   localparam int PP_WIDTH   = GAIN_WIDTH + ERROR_WIDTH;
   localparam int PI_WIDTH   = GAIN_WIDTH + INTEG_WIDTH;
   localparam int PD_WIDTH   = GAIN_WIDTH + DIFF_WIDTH;
   localparam int SUM_WIDTH  = max_int(max_int(PP_WIDTH, PI_WIDTH), PD_WIDTH) + 2;
   localparam int FRAC_BITS  = 8;

endpackage

@@ src/pidc_req_if.sv @@
// Request channel carrying one error sample or a clear request per beat.
interface pidc_req_if;
   import pidc_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [ERROR_WIDTH-1:0]  error_sample;
   logic                           clear_request;

   modport source (output valid, output error_sample, output clear_request, input ready);
   modport sink   (input valid, input error_sample, input clear_request, output ready);
endinterface

@@ src/pidc_rsp_if.sv @@
// Response channel carrying one clamped drive value per beat.
interface pidc_rsp_if;
   import pidc_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [DRIVE_WIDTH-1:0]  drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

@@ src/pidc_csr_if.sv @@
// Register write channel carrying a register index and write data per beat.
interface pidc_csr_if;
   import pidc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [CSR_INDEX_WIDTH-1:0]  index;
   logic [CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/positional_pid_clamped.sv @@
// Positional PID controller with integral separation and clamped integrator, difference and drive.
//
// The block accepts one error sample per beat on the request channel and returns one drive
// value per sample on the response channel, in order. It sustains one beat per clock cycle
// while the response side keeps taking drives: the integrator and previous-error registers
// are updated in the same cycle a sample is accepted, so consecutive samples need no gap.
// A sample's drive passes from the update stage to the multiply stage and then to the
// sum/scale/clamp output register, which drives the response channel.
// Each stage holds when the one after it is full, so
// the request side only stalls when the whole pipeline is backed up. A beat with
// clear_request set zeroes the integrator and the previous error and produces no response.
// The gains are signed Q8.8; the weighted sum is shifted right by 8
// with rounding toward minus infinity and then limited to plus or minus out_limit. Register
// writes are always taken (csr ready is tied high); an index beyond the register list is
// ignored. Registers should only be written while no sample is in flight.
module positional_pid_clamped (
   input  logic        clock,
   input  logic        reset,
   pidc_req_if.sink    req_bus,
   pidc_rsp_if.source  rsp_bus,
   pidc_csr_if.sink    csr_bus
);
   import pidc_pkg::*;

   // ---------------------------------------------------------------------------------------
   // Control registers.
   // ---------------------------------------------------------------------------------------
   logic signed [GAIN_WIDTH-1:0] prop_gain_ff;
   logic signed [GAIN_WIDTH-1:0] integ_gain_ff;
   logic signed [GAIN_WIDTH-1:0] deriv_gain_ff;
   logic [ILIM_WIDTH-1:0]        integ_limit_ff;
   logic [SEP_WIDTH-1:0]         sep_thresh_ff;
   logic [DLIM_WIDTH-1:0]        deriv_limit_ff;
   logic [OLIM_WIDTH-1:0]        out_limit_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= '0;
         integ_gain_ff  <= '0;
         deriv_gain_ff  <= '0;
         integ_limit_ff <= INTEG_LIM_RESET;
         sep_thresh_ff  <= SEP_THRESH_RESET;
         deriv_limit_ff <= DERIV_LIM_RESET;
         out_limit_ff   <= OUT_LIM_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_PROP_GAIN:  prop_gain_ff   <= csr_bus.data[GAIN_WIDTH-1:0];
            CSR_INTEG_GAIN: integ_gain_ff  <= csr_bus.data[GAIN_WIDTH-1:0];
            CSR_DERIV_GAIN: deriv_gain_ff  <= csr_bus.data[GAIN_WIDTH-1:0];
            CSR_INTEG_LIM:  integ_limit_ff <= csr_bus.data[ILIM_WIDTH-1:0];
            CSR_SEP_THRESH: sep_thresh_ff  <= csr_bus.data[SEP_WIDTH-1:0];
            CSR_DERIV_LIM:  deriv_limit_ff <= csr_bus.data[DLIM_WIDTH-1:0];
            CSR_OUT_LIM:    out_limit_ff   <= csr_bus.data[OLIM_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Flow control. Each stage may load when it is empty or when its contents move on in the
   // same cycle; the response register is the last stage.
   // ---------------------------------------------------------------------------------------
   logic upd_valid_ff;
   logic mul_valid_ff;
   logic rsp_valid_ff;
   logic rsp_free;
   logic mul_free;
   logic upd_free;
   logic req_fire;
   logic sample_fire;
   logic clear_fire;

   assign rsp_free    = !rsp_valid_ff || rsp_bus.ready;
   assign mul_free    = !mul_valid_ff || rsp_free;
   assign upd_free    = !upd_valid_ff || mul_free;
   assign req_bus.ready = upd_free;
   assign req_fire    = req_bus.valid && upd_free;
   assign sample_fire = req_fire && !req_bus.clear_request;
   assign clear_fire  = req_fire && req_bus.clear_request;

   // ---------------------------------------------------------------------------------------
   // Update stage: integrator with separation and saturation, clamped error difference.
   // ---------------------------------------------------------------------------------------
   logic signed [ERROR_WIDTH-1:0] prev_error_ff;
   logic signed [INTEG_WIDTH-1:0] integ_ff;

   logic signed [ERROR_WIDTH-1:0] upd_error_ff;
   logic signed [INTEG_WIDTH-1:0] upd_integ_ff;
   logic signed [DIFF_WIDTH-1:0]  upd_diff_ff;

   logic signed [ERROR_WIDTH-1:0] err;
   logic [ERROR_WIDTH-1:0]        err_mag;
   logic                          sep_hit;
   logic [LIMC_WIDTH-1:0]         ilim_wide;
   logic [LIMC_WIDTH-1:0]         imax_wide;
   logic [INTEG_WIDTH-2:0]        ilim;
   logic signed [ISUM_WIDTH-1:0]  isum;
   logic signed [ISUM_WIDTH-1:0]  ilim_pos;
   logic signed [ISUM_WIDTH-1:0]  ilim_neg;
   logic signed [INTEG_WIDTH-1:0] integ_in;
   logic signed [DIFF_WIDTH-1:0]  diff_raw;
   logic signed [DCMP_WIDTH-1:0]  diff_wide;
   logic signed [DCMP_WIDTH-1:0]  dlim_pos;
   logic signed [DCMP_WIDTH-1:0]  dlim_neg;
   logic signed [DIFF_WIDTH-1:0]  diff_in;

   always_comb begin
      err     = req_bus.error_sample;
      // The unsigned magnitude of the most negative error is exact in this width.
      err_mag = err[ERROR_WIDTH-1] ? (~err + 1'b1) : err;
      sep_hit = SEPC_WIDTH'(err_mag) > SEPC_WIDTH'(sep_thresh_ff);

      // The saturation bound never exceeds what the integrator can hold.
      ilim_wide = LIMC_WIDTH'(integ_limit_ff);
      imax_wide = LIMC_WIDTH'({(INTEG_WIDTH-1){1'b1}});
      ilim      = (ilim_wide > imax_wide) ? imax_wide[INTEG_WIDTH-2:0]
                                          : ilim_wide[INTEG_WIDTH-2:0];

      isum     = ISUM_WIDTH'(integ_ff) + ISUM_WIDTH'(err);
      ilim_pos = $signed({{(ISUM_WIDTH-INTEG_WIDTH+1){1'b0}}, ilim});
      ilim_neg = -ilim_pos;

      priority if (sep_hit) begin
         integ_in = '0;
      end else if (isum > ilim_pos) begin
         integ_in = ilim_pos[INTEG_WIDTH-1:0];
      end else if (isum < ilim_neg) begin
         integ_in = ilim_neg[INTEG_WIDTH-1:0];
      end else begin
         integ_in = isum[INTEG_WIDTH-1:0];
      end

      diff_raw  = DIFF_WIDTH'(err) - DIFF_WIDTH'(prev_error_ff);
      diff_wide = DCMP_WIDTH'(diff_raw);
      dlim_pos  = $signed(DCMP_WIDTH'({1'b0, deriv_limit_ff}));
      dlim_neg  = -dlim_pos;

      priority if (diff_wide > dlim_pos) begin
         diff_in = dlim_pos[DIFF_WIDTH-1:0];
      end else if (diff_wide < dlim_neg) begin
         diff_in = dlim_neg[DIFF_WIDTH-1:0];
      end else begin
         diff_in = diff_raw;
      end
   end

   // Controller state follows every accepted beat at once, so the next sample sees it.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         integ_ff      <= '0;
      end else if (clear_fire) begin
         prev_error_ff <= '0;
         integ_ff      <= '0;
      end else if (sample_fire) begin
         prev_error_ff <= err;
         integ_ff      <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_valid_ff <= 1'b0;
      end else if (upd_free) begin
         upd_valid_ff <= sample_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_fire) begin
         upd_error_ff <= err;
         upd_integ_ff <= integ_in;
         upd_diff_ff  <= diff_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Multiply stage: the three gain products, each registered.
   // ---------------------------------------------------------------------------------------
   logic signed [PP_WIDTH-1:0] prod_p_ff;
   logic signed [PI_WIDTH-1:0] prod_i_ff;
   logic signed [PD_WIDTH-1:0] prod_d_ff;
   logic signed [PP_WIDTH-1:0] prod_p_in;
   logic signed [PI_WIDTH-1:0] prod_i_in;
   logic signed [PD_WIDTH-1:0] prod_d_in;
   logic                       mul_load;

   assign mul_load  = upd_valid_ff && mul_free;
   assign prod_p_in = prop_gain_ff * upd_error_ff;
   assign prod_i_in = integ_gain_ff * upd_integ_ff;
   assign prod_d_in = deriv_gain_ff * upd_diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_free) begin
         mul_valid_ff <= upd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_load) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Output stage: sum, drop the Q8.8 fraction (floor), clamp to the drive limit.
   // ---------------------------------------------------------------------------------------
   logic signed [SUM_WIDTH-1:0]   acc;
   logic signed [SUM_WIDTH-1:0]   scaled;
   logic signed [SUM_WIDTH-1:0]   olim_pos;
   logic signed [SUM_WIDTH-1:0]   olim_neg;
   logic signed [DRIVE_WIDTH-1:0] drive_in;
   logic signed [DRIVE_WIDTH-1:0] drive_ff;
   logic                          rsp_load;

   assign rsp_load = mul_valid_ff && rsp_free;

   always_comb begin
      acc      = SUM_WIDTH'(prod_p_ff) + SUM_WIDTH'(prod_i_ff) + SUM_WIDTH'(prod_d_ff);
      scaled   = acc >>> FRAC_BITS;
      olim_pos = $signed(SUM_WIDTH'({1'b0, out_limit_ff}));
      olim_neg = -olim_pos;

      priority if (scaled > olim_pos) begin
         drive_in = olim_pos[DRIVE_WIDTH-1:0];
      end else if (scaled < olim_neg) begin
         drive_in = olim_neg[DRIVE_WIDTH-1:0];
      end else begin
         drive_in = scaled[DRIVE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.drive = drive_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------------

   // A clear beat leaves both state registers at zero and starts no sample.
   a_clear_zeroes_state: assert property (@(posedge clock) disable iff (reset)
      clear_fire |=> (integ_ff == '0) && (prev_error_ff == '0) && !upd_valid_ff)
      else $error("clear beat did not zero the controller state");

   // A sample whose magnitude is above the separation threshold zeroes the integrator.
   a_separation: assert property (@(posedge clock) disable iff (reset)
      sample_fire && sep_hit |=> (integ_ff == '0) && (upd_integ_ff == '0))
      else $error("integrator not zeroed on separation");

   // An accepted sample is captured together with its error value.
   a_sample_captured: assert property (@(posedge clock) disable iff (reset)
      sample_fire |=> upd_valid_ff && (upd_error_ff == $past(err))
                      && (prev_error_ff == $past(err)))
      else $error("accepted sample not captured in the update stage");

   // A full stage whose successor is busy keeps its item.
   a_update_holds: assert property (@(posedge clock) disable iff (reset)
      upd_valid_ff && !mul_free |=> upd_valid_ff && $stable(upd_error_ff))
      else $error("update stage lost an item under stall");

   a_multiply_holds: assert property (@(posedge clock) disable iff (reset)
      mul_valid_ff && !rsp_free |=> mul_valid_ff && $stable(prod_i_ff))
      else $error("multiply stage lost an item under stall");

   // A new response only ever follows a filled multiply stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(mul_valid_ff))
      else $error("response raised without a product behind it");

endmodule

@@ bench/pid_drive_checker.sv @@
// Checker that predicts and compares every drive value of the clamped PID block.
`timescale 1ns / 1ps

module pid_drive_checker (
   input  logic clock,
   input  logic reset,
   pidc_req_if  req_mon,
   pidc_rsp_if  rsp_mon,
   pidc_csr_if  csr_mon,
   output int   mismatches,
   output int   pending,
   output int   drives_checked
);
   import pidc_pkg::*;

   // Register copies, as the block holds them.
   logic signed [GAIN_WIDTH-1:0]  prop_gain;
   logic signed [GAIN_WIDTH-1:0]  integ_gain;
   logic signed [GAIN_WIDTH-1:0]  deriv_gain;
   logic        [ILIM_WIDTH-1:0]  integ_limit;
   logic        [SEP_WIDTH-1:0]   sep_thresh;
   logic        [DLIM_WIDTH-1:0]  deriv_limit;
   logic        [OLIM_WIDTH-1:0]  out_limit;

   // Controller state.
   logic signed [INTEG_WIDTH-1:0] integ_acc;
   logic signed [ERROR_WIDTH-1:0] last_error;

   logic signed [DRIVE_WIDTH-1:0] drive_expect_q[$];

   function automatic longint clamp_mag(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Advances the controller state by one sample and returns the drive it gives.
   function automatic logic signed [DRIVE_WIDTH-1:0] pid_update(
      input logic signed [ERROR_WIDTH-1:0] e);
      longint ev, mag, isat, ilim, diff, acc, y;
      ev   = e;
      mag  = (ev < 0) ? -ev : ev;
      isat = (longint'(1) <<< (INTEG_WIDTH - 1)) - 1;
      ilim = (longint'(integ_limit) > isat) ? isat : longint'(integ_limit);
      if (mag > longint'(sep_thresh)) begin
         integ_acc = '0;
      end else begin
         integ_acc = INTEG_WIDTH'(clamp_mag(longint'(integ_acc) + ev, ilim));
      end
      diff = clamp_mag(ev - longint'(last_error), longint'(deriv_limit));
      acc  = longint'(prop_gain) * ev + longint'(integ_gain) * longint'(integ_acc)
           + longint'(deriv_gain) * diff;
      // The arithmetic shift of a signed value rounds toward minus infinity.
      y = clamp_mag(acc >>> FRAC_BITS, longint'(out_limit));
      last_error = e;
      return DRIVE_WIDTH'(y);
   endfunction

   always @(posedge clock) begin
      logic signed [DRIVE_WIDTH-1:0] want;
      if (reset) begin
         prop_gain   = '0;
         integ_gain  = '0;
         deriv_gain  = '0;
         integ_limit = INTEG_LIM_RESET;
         sep_thresh  = SEP_THRESH_RESET;
         deriv_limit = DERIV_LIM_RESET;
         out_limit   = OUT_LIM_RESET;
         integ_acc   = '0;
         last_error  = '0;
         drive_expect_q.delete();
         mismatches     <= 0;
         pending        <= 0;
         drives_checked <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (drive_expect_q.size() == 0) begin
               $display("%0t: drive beat with nothing pending, expected none, actual %0d",
                        $time, rsp_mon.drive);
               mismatches <= mismatches + 1;
            end else begin
               want = drive_expect_q.pop_front();
               if (rsp_mon.drive !== want) begin
                  $display("%0t: drive mismatch, expected %0d, actual %0d",
                           $time, want, rsp_mon.drive);
                  mismatches <= mismatches + 1;
               end
               drives_checked <= drives_checked + 1;
            end
         end

         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_PROP_GAIN:  prop_gain   = csr_mon.data[GAIN_WIDTH-1:0];
               CSR_INTEG_GAIN: integ_gain  = csr_mon.data[GAIN_WIDTH-1:0];
               CSR_DERIV_GAIN: deriv_gain  = csr_mon.data[GAIN_WIDTH-1:0];
               CSR_INTEG_LIM:  integ_limit = csr_mon.data[ILIM_WIDTH-1:0];
               CSR_SEP_THRESH: sep_thresh  = csr_mon.data[SEP_WIDTH-1:0];
               CSR_DERIV_LIM:  deriv_limit = csr_mon.data[DLIM_WIDTH-1:0];
               CSR_OUT_LIM:    out_limit   = csr_mon.data[OLIM_WIDTH-1:0];
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.clear_request) begin
               integ_acc  = '0;
               last_error = '0;
            end else begin
               drive_expect_q.push_back(pid_update(req_mon.error_sample));
            end
         end

         pending <= drive_expect_q.size();
      end
   end

endmodule

@@ bench/testbench.sv @@
// Top of the bench: clock, reset, stimulus and verdict for the clamped positional PID block.
`timescale 1ns / 1ps

module testbench;
   import pidc_pkg::*;

   // Index past the end of the register list; writes to it must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 3'd7;

   // Random part: this many register settings, each followed by a run of samples.
   localparam int RANDOM_SETTINGS   = 8;
   localparam int ITEMS_PER_SETTING = 138;
   // Length of the one long receiver hold-off, in cycles.
   localparam int LONG_HOLD_CYCLES  = 100;
   // Cycles let pass after the last drive before a register write.
   localparam int SETTLE_CYCLES     = 8;

   logic clock;
   logic reset;

   pidc_req_if req_bus ();
   pidc_rsp_if rsp_bus ();
   pidc_csr_if csr_bus ();

   int mismatches;
   int pending;
   int drives_checked;

   // Shared between the stimulus and the receiver process.
   bit quiet;             // no idling on either side once this is set
   int long_holds_asked;  // bumped by the stimulus to ask for one long receiver hold-off
   int long_holds_done;

   // Bookkeeping for the summary and for shaping the random errors.
   int                            sample_count;
   int                            clear_count;
   int                            setting_count;
   int                            cur_sep;
   logic signed [ERROR_WIDTH-1:0] last_sent;

   positional_pid_clamped dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pid_drive_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .mismatches     (mismatches),
      .pending        (pending),
      .drives_checked (drives_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Safety net: a correct run finishes far below this bound, even with every beat stalled.
   initial begin
      #6_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("positional_pid_clamped test failed");
      $finish;
   end

   // Receiver. It drops ready in short random bursts, and once per request from the
   // stimulus it holds off for a long stretch so that the pipeline fills and the request
   // side stalls. Once the run goes quiet it always accepts.
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_holds_done != long_holds_asked) begin
            long_holds_done = long_holds_asked;
            hold = LONG_HOLD_CYCLES;
         end else if (hold == 0 && !quiet && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 5);
         end
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Offers one request beat and returns at the rising edge where it is taken. The valid
   // stays high on return, so back-to-back calls make a gapless stream.
   task automatic send_item(input logic clr, input logic signed [ERROR_WIDTH-1:0] e);
      @(negedge clock);
      req_bus.valid         <= 1'b1;
      req_bus.clear_request <= clr;
      req_bus.error_sample  <= e;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (clr) begin
         clear_count++;
         last_sent = '0;
      end else begin
         sample_count++;
         last_sent = e;
      end
   endtask

   task automatic idle_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
   endtask

   // Stops offering and waits until every predicted drive has come back. A clear gives
   // no drive and never enters the pipeline; the wait then runs on for SETTLE_CYCLES.
   task automatic drain_pipeline();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0]  value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Writes all seven registers with the block idle. Half the time the unused upper
   // data bits carry noise, which the block has to drop.
   task automatic apply_settings(input logic [15:0] pg, ig, dg, input logic [22:0] il,
                                 input logic [14:0] st, input logic [15:0] dl,
                                 input logic [14:0] ol);
      logic [CSR_DATA_WIDTH-1:0] junk;
      junk = $urandom_range(0, 1) ? CSR_DATA_WIDTH'($urandom) : '0;
      drain_pipeline();
      csr_write(CSR_PROP_GAIN,  {junk[22:16], pg});
      csr_write(CSR_INTEG_GAIN, {junk[22:16], ig});
      csr_write(CSR_DERIV_GAIN, {junk[22:16], dg});
      csr_write(CSR_INTEG_LIM,  il);
      csr_write(CSR_SEP_THRESH, {junk[22:15], st});
      csr_write(CSR_DERIV_LIM,  {junk[22:16], dl});
      csr_write(CSR_OUT_LIM,    {junk[22:15], ol});
      cur_sep = st;
      setting_count++;
   endtask

   // Gains: the two extremes, zero, unity, small values and anything at all.
   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 6))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'h0100;
         4, 5: return 16'(int'($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // Limits: zero, all ones, small values, or any value of the register's width.
   function automatic logic [22:0] pick_limit(input int width);
      logic [22:0] full;
      full = 23'((longint'(1) << width) - 1);
      case ($urandom_range(0, 4))
         0: return '0;
         1: return full;
         2: return 23'($urandom_range(1, 64));
         default: return 23'($urandom) & full;
      endcase
   endfunction

   // Errors are shaped so that the integrator both builds up to its bound and gets
   // separated: values around the threshold, slow walks, extremes and full-range noise.
   function automatic logic signed [ERROR_WIDTH-1:0] pick_error();
      int v;
      case ($urandom_range(0, 5))
         0: v = int'($urandom_range(0, 65535)) - 32768;
         1: v = int'($urandom_range(0, 128)) - 64;
         2: begin
            v = cur_sep + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1)) v = -v;
         end
         3: begin
            case ($urandom_range(0, 3))
               0: v = -32768;
               1: v = -32767;
               2: v = 32767;
               default: v = 0;
            endcase
         end
         4: v = int'(last_sent) + int'($urandom_range(0, 32)) - 16;
         default: v = int'($urandom_range(0, 4000)) - 2000;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return ERROR_WIDTH'(v);
   endfunction

   // A clear now and then; its sample field carries random content that must be ignored.
   task automatic send_random();
      if ($urandom_range(0, 24) == 0) begin
         send_item(1'b1, ERROR_WIDTH'($urandom));
      end else begin
         send_item(1'b0, pick_error());
      end
   endtask

   // Stimulus.
   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.clear_request = 1'b0;
      req_bus.error_sample  = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      quiet                 = 1'b0;
      long_holds_asked      = 0;
      long_holds_done       = 0;
      sample_count          = 0;
      clear_count           = 0;
      setting_count         = 0;
      cur_sep               = int'(SEP_THRESH_RESET);
      last_sent             = '0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // With the reset settings all gains are zero, so the drive must be zero.
      send_item(1'b0, 16'sd1000);
      send_item(1'b0, -16'sd1000);

      // Moderate gains, a threshold inside the range, and integrator and difference limits that are reached easily.
      apply_settings(16'd256, 16'd64, 16'd128, 23'd3000, 15'd20000, 16'd5000, 15'd32767);
      send_item(1'b0, 16'sd0);
      send_item(1'b0, 16'sd32767);     // above threshold: integrator zeroed
      send_item(1'b0, -16'sd32768);    // most negative error, magnitude past any threshold
      send_item(1'b0, -16'sd32767);
      send_item(1'b0, 16'sd20000);     // exactly at the threshold still accumulates
      send_item(1'b0, 16'sd20001);     // one above it separates
      send_item(1'b0, -16'sd20000);
      send_item(1'b0, -16'sd20001);
      send_item(1'b1, 16'sd12345);     // clear, sample ignored
      send_item(1'b0, 16'sd1500);
      send_item(1'b0, 16'sd1500);
      send_item(1'b0, 16'sd1500);      // integrator sits at its bound
      send_item(1'b0, -16'sd1);
      send_item(1'b1, -16'sd1);
      send_item(1'b0, 16'sd10000);     // difference clamped to the derivative limit

      // Gain extremes with the widest limits, and a write to an index that does not exist.
      apply_settings(16'h8000, 16'h7FFF, 16'h7FFF, 23'h7FFFFF, 15'h7FFF, 16'hFFFF, 15'h7FFF);
      csr_write(CSR_UNUSED, 23'h7FFFFF);
      send_item(1'b0, 16'sd32767);
      send_item(1'b0, -16'sd32768);
      send_item(1'b0, 16'sd32767);
      send_item(1'b0, -16'sd32767);

      // Every limit zero: integrator held at zero, difference and drive clamped to zero.
      apply_settings(16'h7FFF, 16'h8000, 16'h8000, 23'd0, 15'd0, 16'd0, 15'd0);
      send_item(1'b0, 16'sd0);
      send_item(1'b0, 16'sd5);
      send_item(1'b0, -16'sd5);
      send_item(1'b0, 16'sd32767);

      // Random settings, each with a run of random samples.
      for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
         apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit(ILIM_WIDTH),
                        15'(pick_limit(SEP_WIDTH)), 16'(pick_limit(DLIM_WIDTH)),
                        15'(pick_limit(OLIM_WIDTH)));
         // The last setting runs with both sides streaming at full rate.
         if (ph == RANDOM_SETTINGS - 1) quiet = 1'b1;
         // In the second setting the receiver stalls for a long time while the sender
         // keeps offering, so the pipeline backs up into the request channel.
         if (ph == 1) long_holds_asked++;
         for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            if (!quiet && !(ph == 1 && n < 40) && $urandom_range(0, 4) == 0) begin
               idle_sender($urandom_range(1, 5));
            end
            send_random();
            // Once mid-run the sender pauses until every drive has come back.
            if (ph == 3 && n == ITEMS_PER_SETTING / 2) drain_pipeline();
         end
      end

      // All stimulus is in. Wait for the outstanding drives, with a bound of its own.
      @(negedge clock);
      req_bus.valid <= 1'b0;
      for (int w = 0; w < 5000 && pending != 0; w++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d error samples and %0d clear beats over %0d register settings.",
               sample_count, clear_count, setting_count);
      $display("Compared %0d drive values, including a long response stall.", drives_checked);
      if (mismatches == 0 && pending == 0) begin
         $display("positional_pid_clamped test passed");
      end else begin
         if (pending != 0) $display("%0t: %0d drive values never arrived", $time, pending);
         $display("positional_pid_clamped test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/pidc_pkg.sv
src/pidc_req_if.sv
src/pidc_rsp_if.sv
src/pidc_csr_if.sv
src/positional_pid_clamped.sv
bench/pid_drive_checker.sv
bench/testbench.sv
